FILE: hw/rtl/spa_pkg.sv
package spa_pkg;

    localparam int BANK_COUNT_DEF = 8;

    localparam int DIFF_W   = 8;
    localparam int WIN_W    = 19;

    localparam logic [15:0] NOMINAL_RESET = 16'd3000;
    localparam logic [2:0]  OFFSET_RESET  = 3'd2;

    localparam logic [4:0]       GAIN_START   = 5'd13;
    localparam logic [4:0]       GAIN_STEP    = 5'd3;
    localparam logic [WIN_W-1:0] WINDOW_BASE  = WIN_W'(2048);
    localparam logic [WIN_W-1:0] WINDOW_LIMIT = WIN_W'(17000);
    localparam logic signed [15:0] OUTER_SLOPE = 16'sd15;
    localparam logic signed [9:0]  OUTER_BIAS  = 10'sd5;
    localparam logic signed [8:0]  OUTER_EDGE  = 9'sd3;
    localparam logic signed [8:0]  INNER_EDGE  = 9'sd1;

    localparam logic CFG_NOMINAL_PERIOD = 1'b0;
    localparam logic CFG_WISHED_OFFSET  = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       restart;
        logic [2:0] queued_bank;
        logic [2:0] completed_bank;
    } t_item;

    typedef struct packed {
        logic we;
        logic index;
        logic [15:0] data;
    } t_cfg_wr;

endpackage

FILE: hw/rtl/sample_period_adapter.sv
// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_restart, i_queued_bank, i_completed_bank
// output    o_out_valid  i_out_stall  o_period, o_window_done, o_average
// config    i_cfg_we     -            i_cfg_index, i_cfg_data
//
// one item per cycle sustained unless the result stalls; an item passes through the
// input register, then adaptation logic into the result register
// synchronous active-low reset clears running state and window, loads the start gain
// a stalled result holds its register; the input register fills and then stalls the input
module sample_period_adapter #(
    parameter int BANK_COUNT = spa_pkg::BANK_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    input  logic [2:0]  i_queued_bank,
    input  logic [2:0]  i_completed_bank,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_period,
    output logic        o_window_done,
    output logic [15:0] o_average,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    spa_pkg::t_item   item;
    spa_pkg::t_cfg_wr cfg;
    logic             out_valid;
    logic             advance;

    assign advance     = !out_valid || !i_out_stall;
    assign cfg.we      = i_cfg_we;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;
    assign o_out_valid = out_valid;

    spa_in_reg u_in_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_restart        (i_restart),
        .i_queued_bank    (i_queued_bank),
        .i_completed_bank (i_completed_bank),
        .i_advance        (advance),
        .o_in_stall       (o_in_stall),
        .o_item           (item)
    );

    spa_adapt #(
        .BANK_COUNT (BANK_COUNT)
    ) u_adapt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_advance     (advance),
        .i_cfg         (cfg),
        .o_out_valid   (out_valid),
        .o_period      (o_period),
        .o_window_done (o_window_done),
        .o_average     (o_average)
    );

endmodule

FILE: hw/rtl/spa_in_reg.sv
module spa_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_restart,
    input  logic [2:0]    i_queued_bank,
    input  logic [2:0]    i_completed_bank,
    input  logic          i_advance,
    output logic          o_in_stall,
    output spa_pkg::t_item o_item
);

    spa_pkg::t_item r_item;
    logic           load;

    assign o_in_stall = r_item.valid && !i_advance;
    assign load       = !r_item.valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (load) begin
            r_item.valid <= i_in_valid;
        end
        if (load && i_in_valid) begin
            r_item.restart        <= i_restart;
            r_item.queued_bank    <= i_queued_bank;
            r_item.completed_bank <= i_completed_bank;
        end
    end

    assign o_item = r_item;

endmodule

FILE: hw/rtl/spa_adapt.sv
module spa_adapt #(
    parameter int BANK_COUNT = spa_pkg::BANK_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spa_pkg::t_item   i_item,
    input  logic             i_advance,
    input  spa_pkg::t_cfg_wr i_cfg,
    output logic             o_out_valid,
    output logic [15:0]      o_period,
    output logic             o_window_done,
    output logic [15:0]      o_average
);

    localparam int DW = $clog2(BANK_COUNT);

    logic [15:0] r_nominal;
    logic [2:0]  r_offset;

    logic [15:0] r_avg;
    logic [15:0] r_count;
    logic [31:0] r_sum;
    logic [4:0]  r_gain;
    logic [2:0]  r_step;

    logic        r_out_valid;
    logic [15:0] r_period;
    logic        r_done;
    logic [15:0] r_avg_out;

    logic [15:0] n_avg;
    logic [15:0] n_count;
    logic [31:0] n_sum;
    logic [4:0]  n_gain;
    logic [2:0]  n_step;
    logic        n_done;
    logic [15:0] n_period;

    logic                    load;
    logic                    reload;
    logic [15:0]             eff_avg;
    logic [15:0]             eff_count;
    logic [31:0]             eff_sum;
    logic [4:0]              eff_gain;
    logic [2:0]              eff_step;
    logic [spa_pkg::DIFF_W-1:0] diff;
    logic [DW-1:0]           bank_gap;
    logic signed [8:0]       err;
    logic signed [9:0]       em;
    logic signed [9:0]       e5;
    logic signed [15:0]      inner;
    logic signed [15:0]      outer;
    logic [15:0]             clks;
    logic [spa_pkg::WIN_W-1:0] win;
    logic [4:0]              shamt;
    logic [31:0]             quot;

    assign load = i_item.valid && i_advance;

    always_comb begin
        reload = i_item.restart || (r_avg == 16'd0);
        if (reload) begin
            eff_avg   = r_nominal;
            eff_count = 16'd0;
            eff_sum   = 32'd0;
            eff_gain  = spa_pkg::GAIN_START;
            eff_step  = 3'd0;
        end else begin
            eff_avg   = r_avg;
            eff_count = r_count;
            eff_sum   = r_sum;
            eff_gain  = r_gain;
            eff_step  = r_step;
        end

        diff = spa_pkg::DIFF_W'(i_item.queued_bank) - spa_pkg::DIFF_W'(i_item.completed_bank);
        bank_gap = diff[DW-1:0];
        err  = $signed(9'(bank_gap)) - $signed(9'(r_offset));

        priority if (err < -spa_pkg::INNER_EDGE) begin
            em = 10'(err) + 10'sd1;
        end else if (err > spa_pkg::INNER_EDGE) begin
            em = 10'(err) - 10'sd1;
        end else begin
            em = 10'sd0;
        end

        priority if (err < -spa_pkg::OUTER_EDGE) begin
            e5 = 10'(err) + spa_pkg::OUTER_BIAS;
        end else if (err > spa_pkg::OUTER_EDGE) begin
            e5 = 10'(err) - spa_pkg::OUTER_BIAS;
        end else begin
            e5 = 10'sd0;
        end

        inner    = 16'(em) * $signed({11'b0, eff_gain});
        outer    = 16'(e5) * spa_pkg::OUTER_SLOPE;
        clks     = eff_avg + 16'(inner) + 16'(outer);
        n_period = clks;

        n_count = eff_count + 16'd1;
        n_sum   = eff_sum + 32'(clks);
        win     = spa_pkg::WINDOW_BASE << eff_step;
        shamt   = 5'($clog2(spa_pkg::WINDOW_BASE)) + 5'(eff_step);
        quot    = n_sum >> shamt;

        n_avg  = eff_avg;
        n_gain = eff_gain;
        n_step = eff_step;
        n_done = 1'b0;
        if (spa_pkg::WIN_W'(n_count) == win) begin
            n_avg   = 16'(quot - 32'd1);
            n_count = 16'd0;
            n_sum   = 32'd0;
            n_done  = 1'b1;
            if (win < spa_pkg::WINDOW_LIMIT) begin
                n_gain = eff_gain - spa_pkg::GAIN_STEP;
                n_step = eff_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= spa_pkg::NOMINAL_RESET;
            r_offset  <= spa_pkg::OFFSET_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                spa_pkg::CFG_NOMINAL_PERIOD: r_nominal <= i_cfg.data;
                spa_pkg::CFG_WISHED_OFFSET:  r_offset  <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= 16'd0;
            r_count <= 16'd0;
            r_sum   <= 32'd0;
            r_gain  <= spa_pkg::GAIN_START;
            r_step  <= 3'd0;
        end else if (load) begin
            r_avg   <= n_avg;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_gain  <= n_gain;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_out_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_period  <= n_period;
            r_done    <= n_done;
            r_avg_out <= n_avg;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_period      = r_period;
    assign o_window_done = r_done;
    assign o_average     = r_avg_out;

endmodule

FILE: hw/rtl/spa_checker.sv
module spa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_period,
    input logic        o_window_done,
    input logic [15:0] o_average
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_period)
            && $stable(o_window_done) && $stable(o_average))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 o_out_valid)
        else $error("accepted item produced no result");

endmodule

bind sample_period_adapter spa_checker u_spa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_period      (o_period),
    .o_window_done (o_window_done),
    .o_average     (o_average)
);
